// ===== design/bra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Types, codes and reset constants for the deadlock-avoiding resource
// allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int REQUESTERS = 4;
  localparam int RES_TYPES  = 4;
  localparam int CNT_W      = 3;
  localparam int WORK_W     = 6;
  localparam int IDX_W      = 2;
  localparam int CLAIM_W    = RES_TYPES * CNT_W;
  localparam int ORDER_W    = 8;
  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOT0   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAIM0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGS   = 4'd8;

  localparam logic [CNT_W-1:0] TOT_RST = 3'd3;
  localparam logic [CLAIM_W-1:0] CLAIM_RST [REQUESTERS] =
    '{12'd1097, 12'd27, 12'd3, 12'd216};

  typedef enum logic [1:0] {
    RT_ALLOC    = 2'd0,
    RT_RELEASE  = 2'd1,
    RT_DEADLOCK = 2'd2,
    RT_UNKNOWN  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    STS_GRANTED     = 3'd0,
    STS_REFUSED     = 3'd1,
    STS_RELEASED    = 3'd2,
    STS_DEADLOCK    = 3'd3,
    STS_NO_DEADLOCK = 3'd4,
    STS_ERROR       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CHECK  = 2'd1,
    ST_SEARCH = 2'd2,
    ST_DEAD   = 2'd3
  } state_t;

endpackage

// ===== design/bankers_resource_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_resource_allocator
// Safe-state resource allocator for four requesters and four resource types,
// with release and deadlock check requests.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start, busy          | in_req_type, in_requester, in_res_kind,
//            |                      | in_amount
//  result    | out_valid (strobe)   | out_status, out_safe_order, out_order_valid
//  config    | cfg_valid, cfg_ready | cfg_index, cfg_wdata
//
//  A request is taken when start is high and busy low. Errors, refusals on
//  free units and releases answer from the check state; a deadlock check
//  answers after a pass over all requester rows; an allocate answers when
//  the safety search ends, which tests one requester row per cycle in one
//  shared compare unit. The result strobe lasts one cycle and cannot be
//  stalled. Reset loads free, held and claim state from the reset constants;
//  a configuration write below index CFG_REGS reloads it from the registers.
// ----------------------------------------------------------------------------
module bankers_resource_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic [bra_pkg::IDX_W-1:0]       in_requester,
  input  logic [bra_pkg::IDX_W-1:0]       in_res_kind,
  input  logic [bra_pkg::CNT_W-1:0]       in_amount,
  output logic                            out_valid,
  output logic [2:0]                      out_status,
  output logic [bra_pkg::ORDER_W-1:0]     out_safe_order,
  output logic                            out_order_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bra_pkg::CLAIM_W-1:0]     cfg_wdata
);
  import bra_pkg::*;

  localparam logic [IDX_W-1:0] REQ_LAST = IDX_W'(REQUESTERS - 1);
  localparam logic [IDX_W:0]   REQ_N    = (IDX_W+1)'(REQUESTERS);
  localparam logic [IDX_W:0]   RES_N    = (IDX_W+1)'(RES_TYPES);

  state_t state_r, state_nxt;

  req_type_t        op_type_r;
  logic [IDX_W-1:0] op_req_r, op_res_r;
  logic [CNT_W-1:0] op_amt_r;

  logic [CNT_W-1:0]   tot_r   [RES_TYPES];
  logic [CLAIM_W-1:0] claim_r [REQUESTERS];
  logic [CNT_W-1:0]   tot_new   [RES_TYPES];
  logic [CLAIM_W-1:0] claim_new [REQUESTERS];

  logic [CNT_W-1:0] free_r [RES_TYPES];
  logic [CNT_W-1:0] held_r [REQUESTERS][RES_TYPES];
  logic [CNT_W-1:0] rem_r  [REQUESTERS][RES_TYPES];

  logic [WORK_W-1:0]     work_r [RES_TYPES];
  logic [REQUESTERS-1:0] done_r;
  logic [IDX_W-1:0]      cand_r, cnt_r;
  logic [ORDER_W-1:0]    order_r, order_add;
  logic                  dead_r;

  logic [CNT_W-1:0] sav_free_r, sav_held_r, sav_rem_r;

  logic               out_valid_r, out_ordv_r;
  status_t            out_status_r;
  logic [ORDER_W-1:0] out_order_r;

  logic [IDX_W-1:0]  row_idx;
  logic [CNT_W-1:0]  cur_free, cur_held, cur_rem;
  logic [WORK_W-1:0] cmp_vec [RES_TYPES];
  logic              fits, in_range, cfg_we, accept;

  logic    do_alloc, do_rel, do_step, do_fin, do_revert, do_dead_init, do_dead_step;
  logic    emit, emit_ordv;
  status_t emit_sts;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_safe_order  = out_order_r;
  assign out_order_valid = out_ordv_r;

  // shared row compare unit
  always_comb begin
    row_idx  = (state_r == ST_CHECK) ? op_req_r : cand_r;
    cur_free = free_r[op_res_r];
    cur_held = held_r[op_req_r][op_res_r];
    cur_rem  = rem_r[op_req_r][op_res_r];
    in_range = ({1'b0, op_req_r} < REQ_N) && ({1'b0, op_res_r} < RES_N);
    fits     = 1'b1;
    for (int r = 0; r < RES_TYPES; r++) begin
      cmp_vec[r] = (state_r == ST_DEAD) ? WORK_W'(free_r[r]) : work_r[r];
      if (WORK_W'(rem_r[row_idx][r]) > cmp_vec[r]) fits = 1'b0;
    end
    order_add = order_r | (ORDER_W'(cand_r) << {cnt_r, 1'b0});
  end

  // new register contents on a configuration write
  always_comb begin
    for (int r = 0; r < RES_TYPES; r++) tot_new[r] = tot_r[r];
    for (int t = 0; t < REQUESTERS; t++) claim_new[t] = claim_r[t];
    if (cfg_index < CFG_CLAIM0) begin
      tot_new[cfg_index[IDX_W-1:0]] = cfg_wdata[CNT_W-1:0];
    end else if (cfg_index < CFG_REGS) begin
      claim_new[cfg_index[IDX_W-1:0]] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    do_alloc     = 1'b0;
    do_rel       = 1'b0;
    do_step      = 1'b0;
    do_fin       = 1'b0;
    do_revert    = 1'b0;
    do_dead_init = 1'b0;
    do_dead_step = 1'b0;
    emit         = 1'b0;
    emit_ordv    = 1'b0;
    emit_sts     = STS_ERROR;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
        case (op_type_r)
          RT_ALLOC: begin
            if (!in_range || op_amt_r > cur_rem) begin
              emit = 1'b1;
            end else if (op_amt_r > cur_free) begin
              emit     = 1'b1;
              emit_sts = STS_REFUSED;
            end else begin
              do_alloc  = 1'b1;
              state_nxt = ST_SEARCH;
            end
          end
          RT_RELEASE: begin
            emit = 1'b1;
            if (in_range && op_amt_r <= cur_held) begin
              do_rel   = 1'b1;
              emit_sts = STS_RELEASED;
            end
          end
          RT_DEADLOCK: begin
            do_dead_init = 1'b1;
            state_nxt    = ST_DEAD;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      ST_SEARCH: begin
        if (!done_r[cand_r] && fits) begin
          do_fin = 1'b1;
          if (cnt_r == REQ_LAST) begin
            emit      = 1'b1;
            emit_sts  = STS_GRANTED;
            emit_ordv = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (cand_r == REQ_LAST) begin
          do_revert = 1'b1;
          emit      = 1'b1;
          emit_sts  = STS_REFUSED;
          state_nxt = ST_IDLE;
        end else begin
          do_step = 1'b1;
        end
      end
      ST_DEAD: begin
        do_dead_step = 1'b1;
        if (cand_r == REQ_LAST) begin
          emit      = 1'b1;
          emit_sts  = (dead_r || !fits) ? STS_DEADLOCK : STS_NO_DEADLOCK;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < RES_TYPES; r++) begin
        tot_r[r]  <= TOT_RST;
        free_r[r] <= TOT_RST;
      end
      for (int t = 0; t < REQUESTERS; t++) begin
        claim_r[t] <= CLAIM_RST[t];
        for (int r = 0; r < RES_TYPES; r++) begin
          held_r[t][r] <= '0;
          rem_r[t][r]  <= CLAIM_RST[t][r*CNT_W +: CNT_W];
        end
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      if (emit) begin
        out_status_r <= emit_sts;
        out_ordv_r   <= emit_ordv;
        out_order_r  <= emit_ordv ? order_add : '0;
      end
      if (cfg_we && cfg_index < CFG_REGS) begin
        for (int r = 0; r < RES_TYPES; r++) begin
          tot_r[r]  <= tot_new[r];
          free_r[r] <= tot_new[r];
        end
        for (int t = 0; t < REQUESTERS; t++) begin
          claim_r[t] <= claim_new[t];
          for (int r = 0; r < RES_TYPES; r++) begin
            held_r[t][r] <= '0;
            rem_r[t][r]  <= claim_new[t][r*CNT_W +: CNT_W];
          end
        end
      end
      if (accept) begin
        op_type_r <= req_type_t'(in_req_type);
        op_req_r  <= in_requester;
        op_res_r  <= in_res_kind;
        op_amt_r  <= in_amount;
      end
      if (do_alloc) begin
        sav_free_r <= cur_free;
        sav_held_r <= cur_held;
        sav_rem_r  <= cur_rem;
        free_r[op_res_r]           <= cur_free - op_amt_r;
        held_r[op_req_r][op_res_r] <= cur_held + op_amt_r;
        rem_r[op_req_r][op_res_r]  <= cur_rem - op_amt_r;
        for (int r = 0; r < RES_TYPES; r++) begin
          work_r[r] <= WORK_W'(free_r[r])
                     - ((IDX_W'(r) == op_res_r) ? WORK_W'(op_amt_r) : '0);
        end
        done_r  <= '0;
        cand_r  <= '0;
        cnt_r   <= '0;
        order_r <= '0;
      end
      if (do_rel) begin
        held_r[op_req_r][op_res_r] <= cur_held - op_amt_r;
        free_r[op_res_r]           <= cur_free + op_amt_r;
      end
      if (do_step) cand_r <= cand_r + 1'b1;
      if (do_fin) begin
        for (int r = 0; r < RES_TYPES; r++) begin
          work_r[r] <= work_r[r] + WORK_W'(held_r[row_idx][r]);
        end
        done_r[cand_r] <= 1'b1;
        order_r        <= order_add;
        cnt_r          <= cnt_r + 1'b1;
        cand_r         <= '0;
      end
      if (do_revert) begin
        free_r[op_res_r]           <= sav_free_r;
        held_r[op_req_r][op_res_r] <= sav_held_r;
        rem_r[op_req_r][op_res_r]  <= sav_rem_r;
      end
      if (do_dead_init) begin
        cand_r <= '0;
        dead_r <= 1'b0;
      end
      if (do_dead_step) begin
        cand_r <= cand_r + 1'b1;
        dead_r <= dead_r || !fits;
      end
    end
  end

`ifndef SYNTHESIS
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != ST_IDLE))
    else $error("result strobe without a request in progress");

  a_order_only_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_ordv_r && out_valid_r |-> out_status_r == STS_GRANTED)
    else $error("order reported without a grant");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> $countones(done_r) == int'(cnt_r))
    else $error("finished set disagrees with finish count");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_CHECK)
    else $error("accepted request did not enter check");
`endif

endmodule
